@@ hw/rtl/ped_pkg.sv @@
`default_nettype none

package ped_pkg;

    // Default coordinate width and the number of fraction bits kept on the length.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS       = 16;

    // Case and sign information that rides along with an item through the pipeline.
    typedef struct packed {
        logic zero_ext;   // extension is zero, endpoint passes through
        logic vert;       // equal x (coinciding points included)
        logic horz;       // equal y
        logic up;         // endpoint y above neighbor y
        logic right;      // endpoint x right of neighbor x
        logic neg_x;      // x step is negative
        logic neg_y;      // y step is negative
    } t_flags;

endpackage

`default_nettype wire

@@ hw/rtl/ped_isqrt.sv @@
`default_nettype none

// Pipelined restoring square root, one root bit per stage.
module ped_isqrt
    import ped_pkg::*;
#(
    parameter int QW = 49,
    parameter int PW = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [2*QW-1:0] i_rad,
    input  wire logic [PW-1:0]   i_pay,
    output logic                 o_valid,
    output logic [QW-1:0]        o_root,
    output logic [PW-1:0]        o_pay
);

    localparam int RMW = QW + 2;

    logic [QW:1]       r_vld;
    logic [2*QW-1:0]   r_rad [1:QW-1];
    logic [RMW-1:0]    r_rem [1:QW-1];
    logic [QW-1:0]     r_res [1:QW];
    logic [PW-1:0]     r_pay [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_st
        localparam int B = 2 * (QW - 1 - k);
        logic [2*QW-1:0] rad;
        logic [RMW-1:0]  rem;
        logic [QW-1:0]   res;
        logic [PW-1:0]   pay;
        logic            vld;
        logic [RMW-1:0]  rem_sh;
        logic [RMW-1:0]  trial;
        logic            ge;

        if (k == 0) begin : g_in
            assign rad = i_rad;
            assign rem = '0;
            assign res = '0;
            assign pay = i_pay;
            assign vld = i_valid;
        end else begin : g_mid
            assign rad = r_rad[k];
            assign rem = r_rem[k];
            assign res = r_res[k];
            assign pay = r_pay[k];
            assign vld = r_vld[k];
        end

        // The partial remainder never exceeds twice the partial root, so the top
        // two bits are free before the shift.
        assign rem_sh = {rem[RMW-3:0], rad[B+1:B]};
        assign trial  = {res, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_res[k+1] <= {res[QW-2:0], ge};
                r_pay[k+1] <= pay;
            end
        end

        if (k < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[k+1] <= rad;
                    r_rem[k+1] <= ge ? (rem_sh - trial) : rem_sh;
                end
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_root  = r_res[QW];
    assign o_pay   = r_pay[QW];

endmodule

`default_nettype wire

@@ hw/rtl/ped_div.sv @@
`default_nettype none

// Two-lane pipelined restoring divider with a shared divisor, one quotient bit
// per stage. The quotient must fit in QB bits.
module ped_div
    import ped_pkg::*;
#(
    parameter int QW = 49,
    parameter int QB = 35,
    parameter int NW = 82,
    parameter int PW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [QW-1:0] i_den,
    input  wire logic [NW-1:0] i_num0,
    input  wire logic [NW-1:0] i_num1,
    input  wire logic [PW-1:0] i_pay,
    output logic               o_valid,
    output logic [QB-1:0]      o_quo0,
    output logic [QB-1:0]      o_quo1,
    output logic [PW-1:0]      o_pay
);

    localparam int DRW = QW + 1;

    logic [QB:1]     r_vld;
    logic [QW-1:0]   r_den [1:QB-1];
    logic [NW-1:0]   r_num [2][1:QB-1];
    logic [DRW-1:0]  r_rem [2][1:QB-1];
    logic [QB-1:0]   r_quo [2][1:QB];
    logic [PW-1:0]   r_pay [1:QB];

    for (genvar k = 0; k < QB; k++) begin : g_st
        localparam int J = QB - 1 - k;
        logic [QW-1:0] den;
        logic [PW-1:0] pay;
        logic          vld;

        if (k == 0) begin : g_in
            assign den = i_den;
            assign pay = i_pay;
            assign vld = i_valid;
        end else begin : g_mid
            assign den = r_den[k];
            assign pay = r_pay[k];
            assign vld = r_vld[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pay[k+1] <= pay;
            end
        end

        if (k < QB - 1) begin : g_den
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k+1] <= den;
                end
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [NW-1:0]  num;
            logic [DRW-1:0] rem;
            logic [QB-1:0]  quo;
            logic [DRW-1:0] rem_sh;
            logic           ge;

            if (k == 0) begin : g_in
                // The bits above the quotient range form the starting remainder.
                assign num = (l == 0) ? i_num0 : i_num1;
                assign rem = DRW'(num[NW-1:QB]);
                assign quo = '0;
            end else begin : g_mid
                assign num = r_num[l][k];
                assign rem = r_rem[l][k];
                assign quo = r_quo[l][k];
            end

            assign rem_sh = {rem[DRW-2:0], num[J]};
            assign ge     = (rem_sh >= {1'b0, den});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_quo[l][k+1] <= {quo[QB-2:0], ge};
                end
            end

            if (k < QB - 1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_num[l][k+1] <= num;
                        r_rem[l][k+1] <= ge ? (rem_sh - {1'b0, den}) : rem_sh;
                    end
                end
            end
        end
    end

    assign o_valid = r_vld[QB];
    assign o_quo0  = r_quo[0][QB];
    assign o_quo1  = r_quo[1][QB];
    assign o_pay   = r_pay[QB];

endmodule

`default_nettype wire

@@ hw/rtl/path_endpoint_extend_top.sv @@
`default_nettype none

// Path endpoint extension.
// The slave channel (i_s_*) takes one endpoint, its neighbor point and a signed
// extension per transfer. The master channel (o_m_*) returns the moved endpoint
// and a flag that is set when either coordinate was clamped to the coordinate range.
// Zero extensions, vertical and horizontal segments are handled exactly; other
// segments are moved by the rounded projection of the extension, computed with
// an exact square root and exact divisions.
// The pipeline has three setup stages, one stage per root bit of the length, one
// stage per quotient bit of the two dividers, and the output register.
// Throughput is one transfer per cycle while the receiver takes results; the
// pipeline holds one item per stage.
// When the receiver stalls a waiting result, the whole pipeline holds and
// o_s_tready goes low in the same cycle; nothing is lost or repeated.
// Reset clears every valid bit; the first transfer may follow right after it.
module path_endpoint_extend_top
    import ped_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_s_tvalid,
    output logic                                           o_s_tready,
    // end_x, end_y, near_x, near_y, extension
    input  wire logic [((5*COORD_WIDTH+7)/8)*8-1:0]        i_s_tdata,
    output logic                                           o_m_tvalid,
    input  wire logic                                      i_m_tready,
    // new_x, new_y
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]             o_m_tdata,
    // saturated
    output logic                                           o_m_tuser
);

    localparam int W      = COORD_WIDTH;
    localparam int DW     = W + 1;
    localparam int SQW    = 2 * W + 2;
    localparam int RW     = SQW + 2 * FRAC_BITS;
    localparam int QW     = RW / 2;
    localparam int PRW    = DW + W;
    localparam int NW     = PRW + FRAC_BITS + 1;
    localparam int QB     = W + 3;
    localparam int SW     = W + 5;
    localparam int FW     = $bits(t_flags);
    localparam int PW2    = 3 * W + FW;
    localparam int PW1    = PW2 + 2 * NW;
    localparam int OUT_TW = ((2 * W + 7) / 8) * 8;

    localparam logic signed [SW-1:0] C_HI = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] C_LO = -C_HI - SW'(1);

    logic en;

    // Input field split and setup.
    logic [W-1:0]         in_ex, in_ey, in_nx, in_ny, in_ext;
    logic signed [DW-1:0] dx, dy;
    t_flags               in_flags;

    assign in_ex  = i_s_tdata[0*W +: W];
    assign in_ey  = i_s_tdata[1*W +: W];
    assign in_nx  = i_s_tdata[2*W +: W];
    assign in_ny  = i_s_tdata[3*W +: W];
    assign in_ext = i_s_tdata[4*W +: W];

    assign dx = $signed({in_ex[W-1], in_ex}) - $signed({in_nx[W-1], in_nx});
    assign dy = $signed({in_ey[W-1], in_ey}) - $signed({in_ny[W-1], in_ny});

    always_comb begin
        in_flags.zero_ext = (in_ext == '0);
        in_flags.vert     = (dx == '0);
        in_flags.horz     = (dy == '0);
        in_flags.up       = (dy > 0);
        in_flags.right    = (dx > 0);
        in_flags.neg_x    = dx[DW-1] ^ in_ext[W-1];
        in_flags.neg_y    = dy[DW-1] ^ in_ext[W-1];
    end

    // Stage 2: magnitudes.
    logic          r2_vld;
    logic [W-1:0]  r2_ex, r2_ey, r2_ext, r2_ae;
    logic [DW-1:0] r2_ax, r2_ay;
    t_flags        r2_flags;

    // Stage 3: products.
    logic          r3_vld;
    logic [W-1:0]  r3_ex, r3_ey, r3_ext;
    logic [SQW-1:0] r3_sx, r3_sy;
    logic [PRW-1:0] r3_px, r3_py;
    t_flags        r3_flags;

    // Stage 4: scaled squared length and numerators.
    logic          r4_vld;
    logic [RW-1:0] r4_rad;
    logic [NW-1:0] r4_numx, r4_numy;
    logic [PW2-1:0] r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= i_s_tvalid;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ex    <= in_ex;
            r2_ey    <= in_ey;
            r2_ext   <= in_ext;
            r2_ax    <= dx[DW-1] ? DW'(-dx) : DW'(dx);
            r2_ay    <= dy[DW-1] ? DW'(-dy) : DW'(dy);
            r2_ae    <= in_ext[W-1] ? W'(-in_ext) : in_ext;
            r2_flags <= in_flags;

            r3_ex    <= r2_ex;
            r3_ey    <= r2_ey;
            r3_ext   <= r2_ext;
            r3_sx    <= r2_ax * r2_ax;
            r3_sy    <= r2_ay * r2_ay;
            r3_px    <= r2_ax * r2_ae;
            r3_py    <= r2_ay * r2_ae;
            r3_flags <= r2_flags;

            r4_rad   <= {SQW'(r3_sx + r3_sy), {(2*FRAC_BITS){1'b0}}};
            r4_numx  <= {r3_px, {(FRAC_BITS+1){1'b0}}};
            r4_numy  <= {r3_py, {(FRAC_BITS+1){1'b0}}};
            r4_side  <= {r3_ex, r3_ey, r3_ext, r3_flags};
        end
    end

    // Length with FRAC_BITS fraction bits.
    logic           sq_vld;
    logic [QW-1:0]  sq_root;
    logic [PW1-1:0] sq_pay;
    logic [NW-1:0]  sq_numx, sq_numy;
    logic [PW2-1:0] sq_side;

    ped_isqrt #(
        .QW (QW),
        .PW (PW1)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_vld),
        .i_rad   (r4_rad),
        .i_pay   ({r4_side, r4_numx, r4_numy}),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_pay   (sq_pay)
    );

    assign {sq_side, sq_numx, sq_numy} = sq_pay;

    logic           dv_vld;
    logic [QB-1:0]  dv_qx, dv_qy;
    logic [PW2-1:0] dv_pay;
    logic [W-1:0]   dv_ex, dv_ey, dv_ext;
    t_flags         dv_flags;

    ped_div #(
        .QW (QW),
        .QB (QB),
        .NW (NW),
        .PW (PW2)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_vld),
        .i_den   (sq_root),
        .i_num0  (sq_numx),
        .i_num1  (sq_numy),
        .i_pay   (sq_side),
        .o_valid (dv_vld),
        .o_quo0  (dv_qx),
        .o_quo1  (dv_qy),
        .o_pay   (dv_pay)
    );

    assign {dv_ex, dv_ey, dv_ext, dv_flags} = dv_pay;

    // Final rounding, case selection and clamping.
    function automatic logic [W:0] clamp_c(input logic signed [SW-1:0] v);
        logic [W:0] r;
        if (v > C_HI) begin
            r = {1'b1, C_HI[W-1:0]};
        end else if (v < C_LO) begin
            r = {1'b1, C_LO[W-1:0]};
        end else begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    logic [W:0] n_cx, n_cy;

    always_comb begin
        logic [SW-1:0]         hx, hy, ox, oy;
        logic                  cx, cy;
        logic signed [SW-1:0]  bx, by, be, sumx, sumy;
        // The rounding bit and the sign of the step fold into one adder:
        // a negative step adds the inverted half quotient with the carry flipped.
        hx   = SW'(dv_qx >> 1);
        hy   = SW'(dv_qy >> 1);
        ox   = dv_flags.neg_x ? ~hx : hx;
        oy   = dv_flags.neg_y ? ~hy : hy;
        cx   = dv_flags.neg_x ^ dv_qx[0];
        cy   = dv_flags.neg_y ^ dv_qy[0];
        bx   = SW'($signed(dv_ex));
        by   = SW'($signed(dv_ey));
        be   = SW'($signed(dv_ext));
        sumx = bx;
        sumy = by;
        if (dv_flags.zero_ext) begin
            sumx = bx;
            sumy = by;
        end else if (dv_flags.vert) begin
            sumy = dv_flags.up ? (by + be) : (by - be);
        end else if (dv_flags.horz) begin
            sumx = dv_flags.right ? (bx + be) : (bx - be);
        end else begin
            sumx = bx + $signed(ox) + $signed(SW'(cx));
            sumy = by + $signed(oy) + $signed(SW'(cy));
        end
        n_cx = clamp_c(sumx);
        n_cy = clamp_c(sumy);
    end

    logic         r_out_vld;
    logic [W-1:0] r_new_x, r_new_y;
    logic         r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_new_x <= n_cx[W-1:0];
            r_new_y <= n_cy[W-1:0];
            r_sat   <= n_cx[W] | n_cy[W];
        end
    end

    // The pipeline moves whenever the output register is empty or being taken.
    assign en         = !r_out_vld || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OUT_TW'({r_new_y, r_new_x});
    assign o_m_tuser  = r_sat;

endmodule

`default_nettype wire

@@ hw/rtl/ped_checker.sv @@
`default_nettype none

module ped_checker
    import ped_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input wire logic                                   i_clk,
    input wire logic                                   i_rst_n,
    input wire logic                                   i_s_tvalid,
    input wire logic                                   o_s_tready,
    input wire logic [((5*COORD_WIDTH+7)/8)*8-1:0]     i_s_tdata,
    input wire logic                                   o_m_tvalid,
    input wire logic                                   i_m_tready,
    input wire logic [((2*COORD_WIDTH+7)/8)*8-1:0]     o_m_tdata,
    input wire logic                                   o_m_tuser
);

    localparam int W = COORD_WIDTH;
    localparam logic [W-1:0] C_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] C_MIN = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0] nx, ny;
    assign nx = o_m_tdata[W-1:0];
    assign ny = o_m_tdata[2*W-1:W];

    // A stalled result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // The input side is blocked exactly while a result waits.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output stall");

    // A clamped result shows a range limit on at least one axis.
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            (nx == C_MAX) || (nx == C_MIN) || (ny == C_MAX) || (ny == C_MIN))
        else $error("saturation flag without a clamped coordinate");

    // Nothing is shown right after reset.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    logic unused_in;
    assign unused_in = i_s_tvalid ^ (^i_s_tdata);

endmodule

bind path_endpoint_extend_top ped_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ped_checker (.*);

`default_nettype wire
